@@ src/pst_pkg.sv @@
// ---------------------------------------------------------------------------
// pst_pkg
// Types, constants and helpers shared by the profile statistics table.
// ---------------------------------------------------------------------------
`default_nettype none
package pst_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int FIELD_COUNT = 17;
   localparam int Q_DEPTH     = 2;
   localparam int Q_W         = $clog2(Q_DEPTH);
   localparam int CSR_W       = 32;

   // item modes
   localparam logic [3:0] MODE_LAST_ADD = 4'd9;
   localparam logic [3:0] MODE_CLASSIFY = 4'd10;
   localparam logic [3:0] MODE_ALLOC    = 4'd11;
   localparam logic [3:0] MODE_READ     = 4'd12;

   // table fields, one RAM each
   localparam logic [4:0] F_CYCLE_TOTAL = 5'd0;
   localparam logic [4:0] F_CYCLE_MIN   = 5'd1;
   localparam logic [4:0] F_CYCLE_MAX   = 5'd2;
   localparam logic [4:0] F_TIME_TOTAL  = 5'd3;
   localparam logic [4:0] F_TIME_MIN    = 5'd4;
   localparam logic [4:0] F_TIME_MAX    = 5'd5;
   localparam logic [4:0] F_CALL        = 5'd6;
   localparam logic [4:0] F_ACC_L1      = 5'd10;
   localparam logic [4:0] F_MISS_L1     = 5'd14;

   // statistic selects
   localparam logic [4:0] SEL_CYCLE_MAX = 5'd2;
   localparam logic [4:0] SEL_AVG_CYC   = 5'd3;
   localparam logic [4:0] SEL_TIME_MAX  = 5'd6;
   localparam logic [4:0] SEL_AVG_TIME  = 5'd7;
   localparam logic [4:0] SEL_LAST      = 5'd18;

   // csr indexes
   localparam logic [2:0] CSR_USE_CAL = 3'd0;
   localparam logic [2:0] CSR_FIX_L1  = 3'd1;
   localparam logic [2:0] CSR_FIX_L2  = 3'd2;
   localparam logic [2:0] CSR_FIX_L3  = 3'd3;
   localparam logic [2:0] CSR_MEAS_L1 = 3'd4;
   localparam logic [2:0] CSR_MEAS_L2 = 3'd5;
   localparam logic [2:0] CSR_MEAS_L3 = 3'd6;

   typedef struct packed {
      logic [3:0]  mode;
      logic [5:0]  slot;
      logic [63:0] value;
      logic [4:0]  stat_select;
   } pst_req_type;

   typedef struct packed {
      logic [63:0] data;
      logic        no_free_slot;
   } pst_rsp_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_CLASSIFY,
      OP_ALLOC,
      OP_READ
   } pst_op_type;

   typedef struct packed {
      pst_op_type  op;
      logic [4:0]  field;
      logic        slot_ok;
      logic [5:0]  slot;
      logic [63:0] value;
      logic [4:0]  sel;
      logic [1:0]  lvl;
   } pst_item_type;

   typedef struct packed {
      logic clearing;
   } pst_back_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } pst_state_type;

   // field behind a plain (non-average) statistic select
   function automatic logic [4:0] sel_to_field(input logic [4:0] sel);
      logic [4:0] f;
      if (sel <= SEL_CYCLE_MAX)     f = sel;
      else if (sel <= SEL_TIME_MAX) f = sel - 5'd1;
      else                          f = sel - 5'd2;
      return f;
   endfunction

endpackage
`default_nettype wire

@@ src/pst_ram.sv @@
// ---------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ src/pst_front.sv @@
// ---------------------------------------------------------------------------
// pst_front
// Config registers, item decode and cache level classify, two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire pst_pkg::pst_req_type  req,
   input  wire logic                  csr_write_enable,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_write_data,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       q_valid,
   output pst_pkg::pst_item_type      q_item
);
   import pst_pkg::*;

   logic        use_cal_ff;
   logic [31:0] fix_l1_ff, fix_l2_ff, fix_l3_ff;
   logic [31:0] meas_l1_ff, meas_l2_ff, meas_l3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_cal_ff <= 1'b0;
         fix_l1_ff  <= 32'd4;
         fix_l2_ff  <= 32'd14;
         fix_l3_ff  <= 32'd50;
         meas_l1_ff <= '0;
         meas_l2_ff <= '0;
         meas_l3_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_USE_CAL: use_cal_ff <= csr_write_data[0];
            CSR_FIX_L1:  fix_l1_ff  <= csr_write_data;
            CSR_FIX_L2:  fix_l2_ff  <= csr_write_data;
            CSR_FIX_L3:  fix_l3_ff  <= csr_write_data;
            CSR_MEAS_L1: meas_l1_ff <= csr_write_data;
            CSR_MEAS_L2: meas_l2_ff <= csr_write_data;
            CSR_MEAS_L3: meas_l3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [32:0]  t1, t2, t3;
   logic         slot_ok;
   logic         enq;
   pst_item_type item;

   always_comb begin
      if (use_cal_ff) begin
         t1 = {1'b0, meas_l1_ff} + {4'b0, meas_l1_ff[31:3]};
         t2 = {1'b0, meas_l2_ff} + {3'b0, meas_l2_ff[31:2]};
         t3 = {1'b0, meas_l3_ff} + {3'b0, meas_l3_ff[31:2]};
      end else begin
         t1 = {1'b0, fix_l1_ff};
         t2 = {1'b0, fix_l2_ff};
         t3 = {1'b0, fix_l3_ff};
      end
      slot_ok    = (32'(req.slot) < SLOT_COUNT);
      item.field = {1'b0, req.mode};
      item.slot_ok = slot_ok;
      item.slot  = req.slot;
      item.value = req.value;
      item.sel   = req.stat_select;
      priority if (req.value <= 64'(t1)) item.lvl = 2'd0;
      else if (req.value <= 64'(t2))     item.lvl = 2'd1;
      else if (req.value <= 64'(t3))     item.lvl = 2'd2;
      else                               item.lvl = 2'd3;
      enq     = 1'b0;
      item.op = OP_ADD;
      priority if (req.mode <= MODE_LAST_ADD) begin
         enq = slot_ok;
      end else if (req.mode == MODE_CLASSIFY) begin
         item.op = OP_CLASSIFY;
         enq     = slot_ok;
      end else if (req.mode == MODE_ALLOC) begin
         item.op = OP_ALLOC;
         enq     = 1'b1;
      end else if (req.mode == MODE_READ) begin
         item.op = OP_READ;
         enq     = 1'b1;
      end else begin
         // unused modes are dropped
         enq     = 1'b0;
      end
   end

   pst_item_type      entry_ff [Q_DEPTH];
   logic [Q_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [Q_W:0]      count_ff;
   logic              push;

   assign push    = accept && enq;
   assign full    = (count_ff == (Q_W+1)'(Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (Q_W+1)'(push) - (Q_W+1)'(pop);
      end
   end
endmodule
`default_nettype wire

@@ src/pst_div.sv @@
// ---------------------------------------------------------------------------
// pst_div
// 64-bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [63:0]      quot
);
   logic [63:0] rem_ff, quo_ff, den_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic [64:0] shifted, diff;
   logic        ge;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = (shifted >= {1'b0, den_ff});
   assign done    = run_ff && (cnt_ff == 6'd63);
   assign quot    = {quo_ff[62:0], ge};

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[63:0] : shifted[63:0];
         quo_ff <= {quo_ff[62:0], ge};
      end
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (done) run_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

@@ src/pst_back.sv @@
// ---------------------------------------------------------------------------
// pst_back
// Executes queued items: read-modify-write on the field RAMs, allocation,
// statistic reads with the average divide, and the clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire pst_pkg::pst_item_type    q_item,
   output logic                          q_pop,
   output pst_pkg::pst_back_status_type  status,
   output logic                          rsp_strobe,
   output pst_pkg::pst_rsp_type          rsp_data
);
   import pst_pkg::*;

   pst_state_type      state_ff, state_in;
   pst_item_type       item_ff, item_in;
   logic [SLOT_W-1:0]  clr_cnt_ff;
   logic [SLOT_W:0]    alloc_ff, alloc_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   pst_rsp_type        rsp_ff, rsp_in;

   logic [63:0]        rd     [FIELD_COUNT];
   logic [63:0]        wdata  [FIELD_COUNT];
   logic               we     [FIELD_COUNT];
   logic [SLOT_W-1:0]  waddr, raddr;

   logic               div_start, div_done;
   logic [63:0]        div_num, div_quot;

   for (genvar i = 0; i < FIELD_COUNT; i++) begin : g_ram
      pst_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_ram (
         .clock (clock),
         .we    (we[i]),
         .waddr (waddr),
         .wdata (wdata[i]),
         .raddr (raddr),
         .rdata (rd[i])
      );
   end

   pst_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (rd[F_CALL]),
      .done  (div_done),
      .quot  (div_quot)
   );

   logic [4:0]  fa, fb;
   logic [63:0] rd_a, res_a;
   logic        is_avg, den_zero;

   always_comb begin
      fa = (item_ff.op == OP_CLASSIFY) ? F_ACC_L1 + 5'(item_ff.lvl) : item_ff.field;
      fb = F_MISS_L1 + 5'(item_ff.lvl) - 5'd1;
      rd_a = rd[fa];
      if (item_ff.op == OP_CLASSIFY) begin
         res_a = rd_a + 64'd1;
      end else if (fa == F_CYCLE_MIN || fa == F_TIME_MIN) begin
         res_a = (rd_a == '0 || item_ff.value < rd_a) ? item_ff.value : rd_a;
      end else if (fa == F_CYCLE_MAX || fa == F_TIME_MAX) begin
         res_a = (item_ff.value > rd_a) ? item_ff.value : rd_a;
      end else begin
         res_a = rd_a + item_ff.value;
      end
      is_avg   = (item_ff.sel == SEL_AVG_CYC || item_ff.sel == SEL_AVG_TIME);
      den_zero = (rd[F_CALL] == '0);
      div_num  = (item_ff.sel == SEL_AVG_CYC) ? rd[F_CYCLE_TOTAL] : rd[F_TIME_TOTAL];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == SLOT_W'(SLOT_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (q_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (item_ff.op == OP_READ && item_ff.slot_ok && is_avg && !den_zero) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:   if (div_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop         = 1'b0;
      item_in       = item_ff;
      alloc_in      = alloc_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      div_start     = 1'b0;
      raddr         = SLOT_W'(q_item.slot);
      waddr         = (state_ff == ST_CLEAR) ? clr_cnt_ff : SLOT_W'(item_ff.slot);
      for (int i = 0; i < FIELD_COUNT; i++) begin
         we[i]    = 1'b0;
         wdata[i] = (item_ff.op == OP_CLASSIFY && 5'(i) == fb) ? rd[i] + 64'd1 : res_a;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
               we[i]    = 1'b1;
               wdata[i] = '0;
            end
         end
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) item_in = q_item;
         end
         ST_EXEC: begin
            unique case (item_ff.op)
               OP_ADD: begin
                  for (int i = 0; i < FIELD_COUNT; i++) we[i] = (5'(i) == fa);
               end
               OP_CLASSIFY: begin
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     we[i] = (5'(i) == fa) || (item_ff.lvl != 2'd0 && 5'(i) == fb);
                  end
               end
               OP_ALLOC: begin
                  rsp_strobe_in = 1'b1;
                  if (alloc_ff == (SLOT_W+1)'(SLOT_COUNT)) begin
                     rsp_in.no_free_slot = 1'b1;
                  end else begin
                     rsp_in.data = 64'(alloc_ff);
                     alloc_in    = alloc_ff + 1'b1;
                  end
               end
               OP_READ: begin
                  if (!item_ff.slot_ok) begin
                     rsp_strobe_in = 1'b1;
                  end else if (is_avg) begin
                     div_start     = !den_zero;
                     rsp_strobe_in = den_zero;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     if (item_ff.sel <= SEL_LAST) rsp_in.data = rd[sel_to_field(item_ff.sel)];
                  end
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            rsp_strobe_in = div_done;
            rsp_in.data   = div_quot;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         alloc_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_ff      <= alloc_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_data        = rsp_ff;
endmodule
`default_nettype wire

@@ src/profile_statistics_table_core.sv @@
// ---------------------------------------------------------------------------
// profile_statistics_table_core
// Per-slot profiling statistics table: allocate, add and read statistics.
// ---------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          beat when start && !busy
//  response  rsp_strobe, rsp_data           one-cycle strobe, no back-pressure
//  config    csr_write_enable/index/data    write when enable high
//
//  Adds, classify and allocate pass through the back end as a RAM read,
//  then a write or a response. Average reads with a nonzero call count
//  continue in the serial divider; other reads respond after the RAM read.
//  After reset a clearing pass over all SLOT_COUNT (64) slots zeroes the field
//  RAMs with busy held high. Busy is also high while the 2-entry queue is full.
// ---------------------------------------------------------------------------
`default_nettype none
module profile_statistics_table_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pst_pkg::pst_req_type  req_data,
   output logic                       rsp_strobe,
   output pst_pkg::pst_rsp_type       rsp_data,
   input  wire logic                  csr_write_enable,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_write_data
);
   import pst_pkg::*;

   logic                full, q_valid, q_pop;
   pst_item_type        q_item;
   pst_back_status_type status;

   assign busy = full || status.clearing;

   pst_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (start && !busy),
      .req              (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pop              (q_pop),
      .full             (full),
      .q_valid          (q_valid),
      .q_item           (q_item)
   );

   pst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire

@@ src/pst_checker.sv @@
// ---------------------------------------------------------------------------
// pst_checker
// Port-level checks for the profile statistics table.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 busy,
   input wire logic                 rsp_strobe,
   input wire pst_pkg::pst_rsp_type rsp_data
);
   // clearing pass holds busy right after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response right after reset");

   // every response needs a RAM read and then the execute state
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back responses");

   a_full_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.no_free_slot) |-> (rsp_data.data == 64'd0))
      else $error("table full with nonzero data");
endmodule

bind profile_statistics_table_core pst_checker u_pst_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
